// ----- src/ptpd_pkg.sv -----
// Shared widths, register map, reset values and types of the pulse digitizer.
package ptpd_pkg;

  localparam int unsigned CELL_W = 64;
  localparam int unsigned TIME_W = 24;
  localparam int unsigned SMP_W  = 16;
  localparam int unsigned AMP_W  = 17;
  localparam int unsigned TDC_W  = 40;

  localparam int unsigned THR_W  = 16;
  localparam int unsigned ADC_W  = 16;
  localparam int unsigned CYC_W  = 24;
  localparam int unsigned BPC_W  = 12;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 128;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ADC_LIMIT = 2'd1;
  localparam logic [1:0] REG_CYCLE_LEN = 2'd2;
  localparam logic [1:0] REG_BINS_CYC  = 2'd3;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd0;
  localparam logic [ADC_W-1:0] ADC_LIMIT_RST = 16'd4095;
  localparam logic [CYC_W-1:0] CYCLE_LEN_RST = 24'd1000;
  localparam logic [BPC_W-1:0] BINS_CYC_RST  = 12'd1024;

  typedef struct packed {
    logic signed [THR_W-1:0] threshold;
    logic [ADC_W-1:0]        adc_limit;
    logic [CYC_W-1:0]        cycle_length;
    logic [BPC_W-1:0]        bins_per_cycle;
  } cfg_t;

endpackage

// ----- src/ptpd_front.sv -----
// Per-sample pulse tracking: crossing detect, peak, bin counter; emits one job per hit pulse.
module ptpd_front #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int BIN_W       = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptpd_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ptpd_pkg::CELL_W-1:0]         in_cell,
  input  logic [ptpd_pkg::TIME_W-1:0]         in_ptime,
  input  logic [ptpd_pkg::SMP_W-1:0]          in_sample,
  input  logic                                in_last,
  output logic                                job_valid,
  input  logic                                job_ready,
  output logic [ptpd_pkg::CELL_W-1:0]         job_cell,
  output logic [ptpd_pkg::TIME_W-1:0]         job_ptime,
  output logic signed [ptpd_pkg::AMP_W-1:0]   job_amp,
  output logic [BIN_W-1:0]                    job_bin
);

  logic signed [SAMPLE_BITS-1:0]    prev_r, prev_nxt;
  logic signed [SAMPLE_BITS-1:0]    peak_r, peak_nxt;
  logic [BIN_W-1:0]                 bin_r, bin_nxt;
  logic                             seen_r, seen_nxt;
  logic [BIN_W-1:0]                 cbin_r, cbin_nxt;

  logic signed [SAMPLE_BITS-1:0]    smp_raw;
  logic signed [ptpd_pkg::SMP_W-1:0] smp_ext, prev_ext;
  logic signed [SAMPLE_BITS:0]      smp_wide, peak_wide;
  logic [SAMPLE_BITS:0]             mag_s, mag_p;
  logic                             hit, accept;
  logic signed [ptpd_pkg::AMP_W-1:0] peak17, negp, lim17;

  assign smp_raw  = in_sample[SAMPLE_BITS-1:0];
  assign smp_ext  = ptpd_pkg::SMP_W'(smp_raw);
  assign prev_ext = ptpd_pkg::SMP_W'(prev_r);
  assign hit      = (prev_ext >= cfg.threshold) && (smp_ext <= cfg.threshold);

  assign smp_wide  = (SAMPLE_BITS+1)'(smp_raw);
  assign peak_wide = (SAMPLE_BITS+1)'(peak_r);
  assign mag_s     = smp_raw[SAMPLE_BITS-1] ? unsigned'(-smp_wide) : unsigned'(smp_wide);
  assign mag_p     = peak_r[SAMPLE_BITS-1] ? unsigned'(-peak_wide) : unsigned'(peak_wide);

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    seen_nxt = seen_r | hit;
    cbin_nxt = hit ? bin_r : cbin_r;
    peak_nxt = (mag_s > mag_p) ? smp_raw : peak_r;
    prev_nxt = smp_raw;
    bin_nxt  = (bin_r != BIN_W'(MAX_SAMPLES - 1)) ? bin_r + 1'b1 : bin_r;
  end

  // amplitude = min(adc_limit, -peak)
  assign peak17 = ptpd_pkg::AMP_W'(peak_nxt);
  assign negp   = -peak17;
  assign lim17  = signed'({1'b0, cfg.adc_limit});

  assign job_valid = accept && in_last && seen_nxt;
  assign job_cell  = in_cell;
  assign job_ptime = in_ptime;
  assign job_amp   = (negp > lim17) ? lim17 : negp;
  assign job_bin   = cbin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      peak_r <= '0;
      bin_r  <= '0;
      seen_r <= 1'b0;
      cbin_r <= '0;
    end else if (accept) begin
      if (in_last) begin
        prev_r <= '0;
        peak_r <= '0;
        bin_r  <= '0;
        seen_r <= 1'b0;
        cbin_r <= '0;
      end else begin
        prev_r <= prev_nxt;
        peak_r <= peak_nxt;
        bin_r  <= bin_nxt;
        seen_r <= seen_nxt;
        cbin_r <= cbin_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> (bin_r == '0) && !seen_r && (peak_r == '0))
    else $error("pulse state not cleared after final sample");

  a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bin_r <= BIN_W'(MAX_SAMPLES - 1))
    else $error("bin counter past saturation");

  a_cbin_behind: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (cbin_r < bin_r) || (bin_r == BIN_W'(MAX_SAMPLES - 1)))
    else $error("crossing bin ahead of bin counter");

endmodule

// ----- src/ptpd_queue.sv -----
// Short job queue between the sample front end and the timing back end.
module ptpd_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count over depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == CNT_W'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

  a_no_phantom_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

// ----- src/ptpd_back.sv -----
// Per-hit timing: serial divide of pulse time by cycle length, scale, add bin, output register.
module ptpd_back #(
  parameter int BIN_W = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptpd_pkg::cfg_t                     cfg,
  input  logic                               job_valid,
  output logic                               job_ready,
  input  logic [ptpd_pkg::CELL_W-1:0]        job_cell,
  input  logic [ptpd_pkg::TIME_W-1:0]        job_ptime,
  input  logic signed [ptpd_pkg::AMP_W-1:0]  job_amp,
  input  logic [BIN_W-1:0]                   job_bin,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptpd_pkg::CELL_W-1:0]        out_cell,
  output logic signed [ptpd_pkg::AMP_W-1:0]  out_amp,
  output logic [ptpd_pkg::TDC_W-1:0]         out_time
);

  localparam int TW    = ptpd_pkg::TIME_W;
  localparam int CNT_W = $clog2(TW);
  localparam int PRD_W = TW + ptpd_pkg::BPC_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                          state_r, state_nxt;
  logic [CNT_W-1:0]                    cnt_r;
  logic [ptpd_pkg::CELL_W-1:0]         cell_r;
  logic signed [ptpd_pkg::AMP_W-1:0]   amp_r;
  logic [BIN_W-1:0]                    bin_r;
  logic [TW-1:0]                       dvd_r;   // dividend in, quotient out
  logic [ptpd_pkg::CYC_W-1:0]          dvs_r;
  logic [TW-1:0]                       rem_r;
  logic [PRD_W-1:0]                    prod_r;
  logic                                out_valid_r;
  logic [ptpd_pkg::CELL_W-1:0]         out_cell_r;
  logic signed [ptpd_pkg::AMP_W-1:0]   out_amp_r;
  logic [ptpd_pkg::TDC_W-1:0]          out_time_r;

  logic [TW:0]                         rem_sh, dvs_ext;
  logic                                qbit;
  logic [TW:0]                         rem_diff;
  logic                                take, out_free;

  assign job_ready = (state_r == ST_IDLE);
  assign take      = job_valid && job_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign rem_sh   = {rem_r, dvd_r[TW-1]};
  assign dvs_ext  = {1'b0, dvs_r};
  assign qbit     = (rem_sh >= dvs_ext);
  assign rem_diff = rem_sh - dvs_ext;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (take) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == CNT_W'(TW - 1)) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_r <= job_cell;
      amp_r  <= job_amp;
      bin_r  <= job_bin;
      dvd_r  <= job_ptime;
      rem_r  <= '0;
      // a cycle length of zero divides as one
      dvs_r  <= (cfg.cycle_length == '0) ? ptpd_pkg::CYC_W'(1) : cfg.cycle_length;
    end else if (state_r == ST_DIV) begin
      rem_r <= qbit ? rem_diff[TW-1:0] : rem_sh[TW-1:0];
      dvd_r <= {dvd_r[TW-2:0], qbit};
    end
    if (state_r == ST_MUL) begin
      prod_r <= PRD_W'(dvd_r) * PRD_W'(cfg.bins_per_cycle);
    end
    // product fits 36 bits, so the 40-bit sum never reaches saturation
    if (state_r == ST_OUT && out_free) begin
      out_cell_r <= cell_r;
      out_amp_r  <= amp_r;
      out_time_r <= ptpd_pkg::TDC_W'(prod_r) + ptpd_pkg::TDC_W'(bin_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_cell  = out_cell_r;
  assign out_amp   = out_amp_r;
  assign out_time  = out_time_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r == ST_DIV && cnt_r == '0)
    else $error("job taken without starting divide");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= CNT_W'(TW - 1))
    else $error("divide step count overrun");

  a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> $past(state_r) == ST_DIV)
    else $error("multiply entered without divide");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented after scaling");

endmodule

// ----- src/pulse_threshold_peak_digitizer.sv -----
// Top level: APB register bank, stream ports, front end, job queue and timing back end.
// Samples are taken one per cycle; in_tready drops only while the two-entry job queue is full.
// A pulse with a crossing gives its result after its final sample is taken, passing through
//   the job queue, the serial time divider, one multiply and the output register load.
// The back end holds one hit at a time and takes the next job only once its result is loaded.
// Synchronous active-low reset clears the registers to defaults and all pulse and queue state.
module pulse_threshold_peak_digitizer #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ptpd_pkg::IN_DATA_W-1:0]      in_tdata,   // cell_id[63:0], pulse_time[87:64], sample[103:88]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ptpd_pkg::OUT_DATA_W-1:0]     out_tdata,  // hit_cell[63:0], amplitude[80:64], crossing_time[120:81]
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ptpd_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [ptpd_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [ptpd_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int BIN_W       = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int JOB_W       = ptpd_pkg::CELL_W + ptpd_pkg::TIME_W + ptpd_pkg::AMP_W + BIN_W;
  localparam int PAD_W       = ptpd_pkg::OUT_DATA_W - ptpd_pkg::CELL_W - ptpd_pkg::AMP_W
                               - ptpd_pkg::TDC_W;

  ptpd_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold      <= ptpd_pkg::THRESHOLD_RST;
      cfg_r.adc_limit      <= ptpd_pkg::ADC_LIMIT_RST;
      cfg_r.cycle_length   <= ptpd_pkg::CYCLE_LEN_RST;
      cfg_r.bins_per_cycle <= ptpd_pkg::BINS_CYC_RST;
    end else if (wr_en) begin
      case (reg_sel)
        ptpd_pkg::REG_THRESHOLD: cfg_r.threshold      <= cfg_pwdata[ptpd_pkg::THR_W-1:0];
        ptpd_pkg::REG_ADC_LIMIT: cfg_r.adc_limit      <= cfg_pwdata[ptpd_pkg::ADC_W-1:0];
        ptpd_pkg::REG_CYCLE_LEN: cfg_r.cycle_length   <= cfg_pwdata[ptpd_pkg::CYC_W-1:0];
        ptpd_pkg::REG_BINS_CYC:  cfg_r.bins_per_cycle <= cfg_pwdata[ptpd_pkg::BPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ptpd_pkg::REG_THRESHOLD: cfg_prdata = ptpd_pkg::APB_DATA_W'(cfg_r.threshold);
      ptpd_pkg::REG_ADC_LIMIT: cfg_prdata = ptpd_pkg::APB_DATA_W'(cfg_r.adc_limit);
      ptpd_pkg::REG_CYCLE_LEN: cfg_prdata = ptpd_pkg::APB_DATA_W'(cfg_r.cycle_length);
      ptpd_pkg::REG_BINS_CYC:  cfg_prdata = ptpd_pkg::APB_DATA_W'(cfg_r.bins_per_cycle);
      default:                 cfg_prdata = '0;
    endcase
  end

  logic                               fj_valid, fj_ready;
  logic [ptpd_pkg::CELL_W-1:0]        fj_cell, bj_cell, o_cell;
  logic [ptpd_pkg::TIME_W-1:0]        fj_ptime, bj_ptime;
  logic signed [ptpd_pkg::AMP_W-1:0]  fj_amp, bj_amp, o_amp;
  logic [BIN_W-1:0]                   fj_bin, bj_bin;
  logic                               bj_valid, bj_ready;
  logic [JOB_W-1:0]                   bj_data;
  logic [ptpd_pkg::TDC_W-1:0]         o_time;

  ptpd_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BIN_W       (BIN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cell   (in_tdata[63:0]),
    .in_ptime  (in_tdata[87:64]),
    .in_sample (in_tdata[103:88]),
    .in_last   (in_tlast),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_cell  (fj_cell),
    .job_ptime (fj_ptime),
    .job_amp   (fj_amp),
    .job_bin   (fj_bin)
  );

  ptpd_queue #(
    .W     (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  ({fj_bin, fj_amp, fj_ptime, fj_cell}),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj_data)
  );

  assign {bj_bin, bj_amp, bj_ptime, bj_cell} = bj_data;

  ptpd_back #(
    .BIN_W (BIN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_cell  (bj_cell),
    .job_ptime (bj_ptime),
    .job_amp   (bj_amp),
    .job_bin   (bj_bin),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cell  (o_cell),
    .out_amp   (o_amp),
    .out_time  (o_time)
  );

  assign out_tdata = {{PAD_W{1'b0}}, o_time, o_amp, o_cell};

endmodule

// ----- bench/tb_top.sv -----
// Self-checking stream testbench for the pulse threshold and peak digitizer.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 500;
  localparam int BIN_LAST = 255;  // bin counter saturation, MAX_SAMPLES - 1
  localparam logic [ptpd_pkg::TDC_W-1:0] TDC_MAX = '1;

  typedef struct {
    logic [ptpd_pkg::CELL_W-1:0]        cell_id;
    logic [ptpd_pkg::TIME_W-1:0]        ptime;
    logic signed [ptpd_pkg::SMP_W-1:0]  smp;
    bit                                 is_last;
  } sample_t;

  typedef struct {
    logic [ptpd_pkg::CELL_W-1:0]        cell_id;
    logic signed [ptpd_pkg::AMP_W-1:0]  amp;
    logic [ptpd_pkg::TDC_W-1:0]         tdc;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ptpd_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ptpd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ptpd_pkg::APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [ptpd_pkg::APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [ptpd_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  pulse_threshold_peak_digitizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // register image and pulse state as the block should hold them
  ptpd_pkg::cfg_t cur_cfg = '{ptpd_pkg::THRESHOLD_RST, ptpd_pkg::ADC_LIMIT_RST,
                              ptpd_pkg::CYCLE_LEN_RST, ptpd_pkg::BINS_CYC_RST};
  logic signed [ptpd_pkg::SMP_W-1:0] prev_smp = '0;
  logic signed [ptpd_pkg::SMP_W-1:0] peak_smp = '0;
  int unsigned bin_cnt = 0;
  int unsigned xing_bin = 0;
  bit xing_seen = 1'b0;

  sample_t sample_q[$];
  sample_t cur_in;
  hit_t hit_q[$];

  int in_offered = 0;
  int in_accepted = 0;
  int in_idle_pct = 33;
  int out_idle_pct = 33;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int n_err = 0;
  int n_items = 0;
  int n_pulses = 0;
  int n_hits = 0;
  int n_settings = 0;
  int cycle_cnt = 0;

  task automatic report_bad(input string what, input logic [63:0] want, input logic [63:0] got);
    n_err++;
    if (n_err <= 10)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endtask

  // Front end and back end of the digitizer, one accepted sample at a time.
  task automatic digitize_sample(input sample_t s);
    logic signed [ptpd_pkg::SMP_W-1:0] thr;
    int mag_new;
    int mag_pk;
    longint amp;
    longint lim;
    longint unsigned cyc;
    longint unsigned tm;
    longint unsigned bpc;
    longint unsigned tdc;
    hit_t h;
    thr = cur_cfg.threshold;
    if (prev_smp >= thr && s.smp <= thr) begin
      xing_seen = 1'b1;
      xing_bin = bin_cnt;
    end
    mag_new = s.smp;
    if (mag_new < 0) mag_new = -mag_new;
    mag_pk = peak_smp;
    if (mag_pk < 0) mag_pk = -mag_pk;
    if (mag_new > mag_pk) peak_smp = s.smp;
    prev_smp = s.smp;
    if (bin_cnt < BIN_LAST) bin_cnt++;
    if (s.is_last) begin
      if (xing_seen) begin
        amp = peak_smp;
        amp = -amp;
        lim = cur_cfg.adc_limit;
        if (amp > lim) amp = lim;
        cyc = (cur_cfg.cycle_length == 0) ? 1 : cur_cfg.cycle_length;
        tm = s.ptime;
        bpc = cur_cfg.bins_per_cycle;
        tdc = xing_bin + (tm / cyc) * bpc;
        if (tdc > TDC_MAX) tdc = TDC_MAX;
        h.cell_id = s.cell_id;
        h.amp = amp[ptpd_pkg::AMP_W-1:0];
        h.tdc = tdc[ptpd_pkg::TDC_W-1:0];
        hit_q.push_back(h);
      end
      prev_smp = '0;
      peak_smp = '0;
      bin_cnt = 0;
      xing_seen = 1'b0;
      xing_bin = 0;
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && in_accepted != in_offered)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        cur_in = sample_q.pop_front();
        in_offered++;
        in_tdata <= {cur_in.smp, cur_in.ptime, cur_in.cell_id};
        in_tlast <= cur_in.is_last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      digitize_sample(cur_in);
      in_accepted++;
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin : hit_check
    hit_t got;
    hit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cell_id = out_tdata[63:0];
      got.amp = out_tdata[80:64];
      got.tdc = out_tdata[120:81];
      if (hit_q.size() == 0) begin
        report_bad("hit with none pending", '0, got.cell_id);
      end else begin
        want = hit_q.pop_front();
        n_hits++;
        if (got.cell_id !== want.cell_id) report_bad("hit_cell", want.cell_id, got.cell_id);
        if (got.amp !== want.amp) report_bad("amplitude", want.amp, got.amp);
        if (got.tdc !== want.tdc) report_bad("crossing_time", want.tdc, got.tdc);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d hits pending", cycle_cnt, hit_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      ptpd_pkg::REG_THRESHOLD: cur_cfg.threshold = v[ptpd_pkg::THR_W-1:0];
      ptpd_pkg::REG_ADC_LIMIT: cur_cfg.adc_limit = v[ptpd_pkg::ADC_W-1:0];
      ptpd_pkg::REG_CYCLE_LEN: cur_cfg.cycle_length = v[ptpd_pkg::CYC_W-1:0];
      default:                 cur_cfg.bins_per_cycle = v[ptpd_pkg::BPC_W-1:0];
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] got;
    logic [31:0] want;
    logic [31:0] mask;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      ptpd_pkg::REG_THRESHOLD: begin
        want = {16'd0, cur_cfg.threshold};
        mask = 32'h0000_FFFF;
      end
      ptpd_pkg::REG_ADC_LIMIT: begin
        want = {16'd0, cur_cfg.adc_limit};
        mask = 32'h0000_FFFF;
      end
      ptpd_pkg::REG_CYCLE_LEN: begin
        want = {8'd0, cur_cfg.cycle_length};
        mask = 32'h00FF_FFFF;
      end
      default: begin
        want = {20'd0, cur_cfg.bins_per_cycle};
        mask = 32'h0000_0FFF;
      end
    endcase
    if ((got & mask) !== want) report_bad($sformatf("register %0d readback", idx), want, got);
  endtask

  // all items taken, all hits back, back end given time to settle
  task automatic wait_drain();
    while (sample_q.size() != 0 || in_accepted != in_offered || hit_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input int thr, input int adc, input int cyc, input int bpc);
    wait_drain();
    write_reg(ptpd_pkg::REG_THRESHOLD, thr);
    write_reg(ptpd_pkg::REG_ADC_LIMIT, adc);
    write_reg(ptpd_pkg::REG_CYCLE_LEN, cyc);
    write_reg(ptpd_pkg::REG_BINS_CYC, bpc);
    check_reg(ptpd_pkg::REG_THRESHOLD);
    check_reg(ptpd_pkg::REG_ADC_LIMIT);
    check_reg(ptpd_pkg::REG_CYCLE_LEN);
    check_reg(ptpd_pkg::REG_BINS_CYC);
    n_settings++;
  endtask

  task automatic push_smp(input logic [63:0] c, input logic [23:0] t, input int v,
                          input bit l);
    sample_t s;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    s.cell_id = c;
    s.ptime = t;
    s.smp = ptpd_pkg::SMP_W'(v);
    s.is_last = l;
    sample_q.push_back(s);
    n_items++;
    if (l) n_pulses++;
  endtask

  function automatic logic [63:0] rand_cell();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [23:0] rand_ptime();
    case ($urandom_range(3))
      0: return 24'($urandom_range(0, 2000));
      1: return 24'hFFFFFF - 24'($urandom_range(0, 100));
      default: return 24'($urandom);
    endcase
  endfunction

  // Shaped pulses sit above threshold except for one dip below it and occasional noise samples;
  // the rest is full-range noise. Identity may vary until the final sample.
  task automatic gen_pulse(input int n, input bit shaped);
    logic [63:0] c;
    logic [23:0] t;
    int thr;
    int lo;
    int hi;
    int v;
    bit mixed;
    c = rand_cell();
    t = rand_ptime();
    thr = $signed(cur_cfg.threshold);
    mixed = ($urandom_range(9) < 3);
    lo = $urandom_range(0, n - 1);
    hi = $urandom_range(lo, n - 1);
    if (n > BIN_LAST + 1) begin
      // dip after the bin counter has saturated
      lo = n - 1 - $urandom_range(0, 8);
      hi = n - 1;
    end
    for (int i = 0; i < n; i++) begin
      if (!shaped || $urandom_range(9) == 0)
        v = int'($urandom_range(0, 65535)) - 32768;
      else if (i >= lo && i <= hi)
        v = thr - int'($urandom_range(0, 20000));
      else
        v = thr + int'($urandom_range(0, 3000));
      if (i == n - 1 || !mixed)
        push_smp(c, t, v, i == n - 1);
      else
        push_smp(rand_cell(), rand_ptime(), v, 1'b0);
    end
  endtask

  task automatic run_phase(input int budget, input int long_n);
    int start;
    int r;
    int len;
    start = n_items;
    if (long_n > 0) gen_pulse(long_n, 1'b1);
    while (n_items - start < budget) begin
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      gen_pulse(len, $urandom_range(99) < 80);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    check_reg(ptpd_pkg::REG_THRESHOLD);
    check_reg(ptpd_pkg::REG_ADC_LIMIT);
    check_reg(ptpd_pkg::REG_CYCLE_LEN);
    check_reg(ptpd_pkg::REG_BINS_CYC);

    // directed, reset settings
    push_smp('1, 24'hFFFFFF, -32768, 1'b1);          // deepest sample, clamped amplitude
    push_smp('0, '0, 32767, 1'b1);                   // no crossing, no hit
    push_smp('0, '0, 0, 1'b1);                       // sample equal to threshold
    push_smp(64'h0123_4567_89AB_CDEF, 24'd5, 100, 1'b0);
    push_smp(64'hFEDC_BA98_7654_3210, 24'd777, 300, 1'b0);
    push_smp(64'hA5A5_5A5A_0F0F_F0F0, 24'd999, -300, 1'b1);   // tie keeps first peak
    push_smp(64'h1, 24'd1000, 50, 1'b0);
    push_smp(64'h2, 24'd1000, -50, 1'b0);
    push_smp(64'h3, 24'd1000, 60, 1'b0);
    push_smp(64'h4, 24'd1000, -10, 1'b0);
    push_smp(64'h5, 24'd1000, 20, 1'b1);             // later crossing wins
    push_smp(64'h8000_0000_0000_0000, 24'h800000, 5000, 1'b0);
    push_smp(64'h7FFF_FFFF_FFFF_FFFF, 24'h7FFFFF, -5000, 1'b1);
    push_smp(64'h55, 24'd3, -1, 1'b0);
    push_smp(64'h66, 24'd4, 1, 1'b1);                // crossing at bin 0 only

    // output held off while input streams hits at full rate
    set_config(-200, 65535, 1, 4095);
    in_idle_pct = 0;
    hold_armed = 1'b1;
    run_phase(90, 0);
    in_idle_pct = 33;

    set_config(32767, 0, 24'hFFFFFF, 1);
    run_phase(90, $urandom_range(270, 280));

    set_config(-32768, 30000, 0, 0);
    run_phase(90, 0);

    // no idling on either side
    set_config(0, 4095, 1000, 1024);
    in_idle_pct = 0;
    out_idle_pct = 0;
    run_phase(90, 0);
    in_idle_pct = 33;
    out_idle_pct = 33;

    repeat (3) begin
      set_config(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 65535),
                 $urandom_range(1, 5000), $urandom_range(1, 4095));
      run_phase(90, 0);
    end

    wait_drain();
    foreach (hit_q[i]) report_bad("hit never delivered", hit_q[i].cell_id, '0);
    $display("Covered %0d samples in %0d pulses, %0d hits compared, %0d register settings.",
             n_items, n_pulses, n_hits, n_settings);
    $display("Included a saturated long pulse and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (n_err == 0 && hit_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ptpd_pkg.sv
src/ptpd_front.sv
src/ptpd_queue.sv
src/ptpd_back.sv
src/pulse_threshold_peak_digitizer.sv
bench/tb_top.sv
